// ===== hdl/bspl_pkg.sv =====
// ----------------------------------------------------------------------------
// bspl_pkg: shared types and constants of the byte stream pattern locator
// Configuration layout, result layout and sizing of the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

package bspl_pkg;

  // Search geometry
  localparam int unsigned NEEDLE_MAX   = 8;
  localparam int unsigned OFFSET_WIDTH = 32;
  localparam int unsigned WinDepth     = 8;
  localparam int unsigned WinIdxW      = $clog2(WinDepth);
  localparam int unsigned FillW        = $clog2(WinDepth + 1);

  // Field widths
  localparam int unsigned ByteW    = 8;
  localparam int unsigned NeedleW  = 64;
  localparam int unsigned LenW     = 4;
  localparam int unsigned CountW   = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned OutDataW = OFFSET_WIDTH + CountW;

  // Result queue sizing
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef enum logic {
    KIND_MATCH = 1'b0,
    KIND_DONE  = 1'b1
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_NEEDLE_BYTES  = 2'd0,
    REG_NEEDLE_LENGTH = 2'd1,
    REG_MAX_MATCHES   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [NeedleW-1:0] needle_bytes;
    logic [LenW-1:0]    needle_length;
    logic [CountW-1:0]  max_matches;
  } cfg_t;

  typedef struct packed {
    kind_e                   item_kind;
    logic [OFFSET_WIDTH-1:0] match_offset;
    logic [CountW-1:0]       match_total;
    logic                    run_end;
  } result_t;

  // Results of one byte, packed from res0 up; count is 0, 1 or 2
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } step_res_t;

endpackage

`default_nettype wire

// ===== hdl/bspl_match.sv =====
// ----------------------------------------------------------------------------
// bspl_match: search state and match decision
// Holds the byte window, offset, blocking bound and match count, and forms
// the results of one byte combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module bspl_match (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               step_i,
  input  wire logic [bspl_pkg::ByteW-1:0]         data_byte_i,
  input  wire logic                               buffer_end_i,
  input  wire bspl_pkg::cfg_t                     cfg_i,
  output bspl_pkg::step_res_t                     res_o
);

  localparam logic [bspl_pkg::OFFSET_WIDTH-1:0] OffMax = '1;

  logic [bspl_pkg::ByteW-1:0]        win_q [bspl_pkg::WinDepth];
  logic [bspl_pkg::ByteW-1:0]        win_d [bspl_pkg::WinDepth];
  logic [bspl_pkg::FillW-1:0]        fill_q, fill_d;
  logic [bspl_pkg::OFFSET_WIDTH-1:0] pos_q, pos_d;
  logic [bspl_pkg::OFFSET_WIDTH-1:0] blocked_q, blocked_d;
  logic [bspl_pkg::CountW-1:0]       found_q, found_d;

  logic [bspl_pkg::LenW-1:0]         eff_len;
  logic [bspl_pkg::LenW-1:0]         len_m1;
  logic [bspl_pkg::OFFSET_WIDTH-1:0] start_pos;
  logic [bspl_pkg::OFFSET_WIDTH-1:0] end_pos;
  logic                              bytes_ok;
  logic                              hit;
  bspl_pkg::result_t                 match_res, done_res;

  always_comb begin
    logic [bspl_pkg::LenW-1:0] lane;
    // Shift the new byte in; newest sits at index zero
    win_d[0] = data_byte_i;
    for (int j = 1; j < bspl_pkg::WinDepth; j++) begin
      win_d[j] = win_q[j-1];
    end
    fill_d = (fill_q < bspl_pkg::FillW'(bspl_pkg::WinDepth)) ?
             fill_q + bspl_pkg::FillW'(1) : fill_q;

    // Clamp the length to the needle capacity
    if (cfg_i.needle_length > bspl_pkg::LenW'(bspl_pkg::NEEDLE_MAX)) begin
      eff_len = bspl_pkg::LenW'(bspl_pkg::NEEDLE_MAX);
    end else begin
      eff_len = cfg_i.needle_length;
    end
    len_m1 = eff_len - bspl_pkg::LenW'(1);

    // Needle byte i lines up with window entry len-1-i
    bytes_ok = 1'b1;
    lane     = '0;
    for (int i = 0; i < bspl_pkg::WinDepth; i++) begin
      if (bspl_pkg::LenW'(i) < eff_len) begin
        lane = len_m1 - bspl_pkg::LenW'(i);
        if (win_d[lane[bspl_pkg::WinIdxW-1:0]] !=
            cfg_i.needle_bytes[bspl_pkg::ByteW*i +: bspl_pkg::ByteW]) begin
          bytes_ok = 1'b0;
        end
      end
    end

    start_pos = pos_q - bspl_pkg::OFFSET_WIDTH'(len_m1);
    // start + len equals pos + 1; saturate at the top offset
    end_pos   = (pos_q == OffMax) ? OffMax : pos_q + bspl_pkg::OFFSET_WIDTH'(1);

    hit = (eff_len != '0) &&
          (fill_d >= bspl_pkg::FillW'(eff_len)) &&
          (pos_q >= bspl_pkg::OFFSET_WIDTH'(len_m1)) &&
          (found_q < cfg_i.max_matches) &&
          bytes_ok &&
          (start_pos >= blocked_q);

    found_d   = hit ? found_q + bspl_pkg::CountW'(1) : found_q;
    blocked_d = hit ? end_pos : blocked_q;
    pos_d     = (pos_q == OffMax) ? pos_q : pos_q + bspl_pkg::OFFSET_WIDTH'(1);

    match_res.item_kind    = bspl_pkg::KIND_MATCH;
    match_res.match_offset = start_pos;
    match_res.match_total  = found_d;
    match_res.run_end      = ~buffer_end_i;

    done_res.item_kind    = bspl_pkg::KIND_DONE;
    done_res.match_offset = '0;
    done_res.match_total  = found_d;
    done_res.run_end      = 1'b1;

    res_o.res0  = hit ? match_res : done_res;
    res_o.res1  = done_res;
    res_o.count = step_i ? (2'(hit) + 2'(buffer_end_i)) : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < bspl_pkg::WinDepth; j++) begin
        win_q[j] <= '0;
      end
      fill_q    <= '0;
      pos_q     <= '0;
      blocked_q <= '0;
      found_q   <= '0;
    end else if (step_i) begin
      if (buffer_end_i) begin
        // Buffer done: clear for the next one
        for (int j = 0; j < bspl_pkg::WinDepth; j++) begin
          win_q[j] <= '0;
        end
        fill_q    <= '0;
        pos_q     <= '0;
        blocked_q <= '0;
        found_q   <= '0;
      end else begin
        for (int j = 0; j < bspl_pkg::WinDepth; j++) begin
          win_q[j] <= win_d[j];
        end
        fill_q    <= fill_d;
        pos_q     <= pos_d;
        blocked_q <= blocked_d;
        found_q   <= found_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bspl_fifo.sv =====
// ----------------------------------------------------------------------------
// bspl_fifo: result queue
// Takes up to two results per cycle, hands out one per cycle from the head on pop_i.
// ----------------------------------------------------------------------------
`default_nettype none

module bspl_fifo (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire bspl_pkg::step_res_t                push_i,
  input  wire logic                               pop_i,
  output bspl_pkg::result_t                       head_o,
  output logic                                    valid_o,
  output logic [bspl_pkg::FifoCntW-1:0]           count_o
);

  bspl_pkg::result_t                 mem_q [bspl_pkg::FifoDepth];
  logic [bspl_pkg::FifoPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [bspl_pkg::FifoPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [bspl_pkg::FifoCntW-1:0]     cnt_q, cnt_d;
  logic [bspl_pkg::FifoPtrW-1:0]     wr_ptr_nx;

  always_comb begin
    wr_ptr_nx = wr_ptr_q + bspl_pkg::FifoPtrW'(1);
    wr_ptr_d  = wr_ptr_q + bspl_pkg::FifoPtrW'(push_i.count);
    rd_ptr_d  = pop_i ? rd_ptr_q + bspl_pkg::FifoPtrW'(1) : rd_ptr_q;
    cnt_d     = cnt_q + bspl_pkg::FifoCntW'(push_i.count) - bspl_pkg::FifoCntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign valid_o = (cnt_q != '0);
  assign count_o = cnt_q;

endmodule

`default_nettype wire

// ===== hdl/byte_stream_pattern_locator_top.sv =====
// ----------------------------------------------------------------------------
// byte_stream_pattern_locator_top: non-overlapping needle search on a byte stream
// Reports the offset of each non-overlapping needle occurrence in a buffer,
// up to max_matches, and a closing item with the match count on the buffer's last byte.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                                   Handshake
//  --------  ---------  ----------------------------------------  ---------------
//  s_axis    in         tdata[7:0] data_byte, tlast buffer_end    tvalid / tready
//  m_axis    out        tdata[31:0] match_offset,                 tvalid / tready
//                       tdata[63:32] match_total,
//                       tuser item_kind, tlast run_end
//  cfg       in         index 0 needle_bytes, 1 needle_length,   cfg_valid_i /
//                       2 max_matches; data in cfg_data_i         cfg_ready_o
//
//  One byte per cycle while the queue has room: a byte lands in the input
//  register, is compared and retired from there, and its results go into a
//  four-entry queue. A byte with both a match and the closing item puts two
//  results in the queue, which drains one per cycle while m_axis_tready is high.
//  Input stalls only when the queue cannot take two more.
//  Reset clears the search state and sets needle length and match limit to 1.
//  Config writes are always taken and apply to the next retired byte.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_stream_pattern_locator_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Input byte stream
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [bspl_pkg::ByteW-1:0]          s_axis_tdata,  // [7:0] data_byte
  input  wire logic                                s_axis_tlast,
  // Result stream
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic [bspl_pkg::OutDataW-1:0]            m_axis_tdata,  // [31:0] match_offset,
                                                                  // [63:32] match_total
  output logic                                     m_axis_tuser,  // [0] item_kind
  output logic                                     m_axis_tlast,
  // Configuration write channel
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [bspl_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [bspl_pkg::NeedleW-1:0]        cfg_data_i
);

  // Configuration registers
  bspl_pkg::cfg_t                   cfg_q;

  // Input register
  logic                             in_valid_q;
  logic [bspl_pkg::ByteW-1:0]       in_byte_q;
  logic                             in_last_q;

  logic                             pop;
  logic                             room;
  logic                             step;
  logic                             in_take;
  bspl_pkg::step_res_t              step_res;
  bspl_pkg::result_t                head;
  logic                             head_valid;
  logic [bspl_pkg::FifoCntW-1:0]    fifo_cnt;

  // Config port never stalls
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.needle_bytes  <= '0;
      cfg_q.needle_length <= bspl_pkg::LenW'(1);
      cfg_q.max_matches   <= bspl_pkg::CountW'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bspl_pkg::REG_NEEDLE_BYTES:  cfg_q.needle_bytes  <= cfg_data_i;
        bspl_pkg::REG_NEEDLE_LENGTH: cfg_q.needle_length <= cfg_data_i[bspl_pkg::LenW-1:0];
        bspl_pkg::REG_MAX_MATCHES:   cfg_q.max_matches   <= cfg_data_i[bspl_pkg::CountW-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Retire the held byte only if the queue keeps room for two results after
  // this cycle's pop
  always_comb begin
    pop     = head_valid & m_axis_tready;
    room    = (fifo_cnt - bspl_pkg::FifoCntW'(pop)) <=
              bspl_pkg::FifoCntW'(bspl_pkg::FifoDepth - 2);
    step    = in_valid_q & room;
    in_take = s_axis_tvalid & s_axis_tready;
  end

  assign s_axis_tready = ~in_valid_q | step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  // Payload holds until the next transaction
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  bspl_match u_match (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .data_byte_i  (in_byte_q),
    .buffer_end_i (in_last_q),
    .cfg_i        (cfg_q),
    .res_o        (step_res)
  );

  bspl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step_res),
    .pop_i   (pop),
    .head_o  (head),
    .valid_o (head_valid),
    .count_o (fifo_cnt)
  );

  // Drive the result stream from the queue head
  assign m_axis_tvalid = head_valid;
  assign m_axis_tdata  = {head.match_total, head.match_offset};
  assign m_axis_tuser  = head.item_kind;
  assign m_axis_tlast  = head.run_end;

endmodule

`default_nettype wire
